### rtl/cstrip_pkg.sv
`timescale 1ns / 1ps

package cstrip_pkg;

   // Number of entries used in each of the block and line opener tables (1 or 2).
   localparam int NUM_VARIANTS = 2;

   // Result queue depth; a power of two, at least 4.
   localparam int FIFO_DEPTH = 4;

   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

   // Configuration register indexes.
   localparam logic [2:0] REG_BLOCK_A      = 3'd0;
   localparam logic [2:0] REG_LINE_A       = 3'd2;
   localparam logic [2:0] REG_DFLT_BLOCK   = 3'd4;
   localparam logic [2:0] REG_DFLT_LINE    = 3'd5;

   localparam logic [23:0] DFLT_BLOCK_RESET = 24'h002A2F;
   localparam logic [15:0] DFLT_LINE_RESET  = 16'h2F2F;

   typedef enum logic [1:0] {
      MODE_TEXT  = 2'd0,
      MODE_LINE  = 2'd1,
      MODE_BLOCK = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [23:0] variant;
   } scan_type;

   typedef struct packed {
      logic [NUM_VARIANTS-1:0][23:0] block_op;
      logic [NUM_VARIANTS-1:0][15:0] line_op;
      logic [23:0]                   dflt_block;
      logic [15:0]                   dflt_line;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
      logic       err;
   } result_type;

endpackage

### rtl/comment_stripper.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_stall   req_in_byte, req_in_last
// rsp      out        rsp_valid / rsp_stall   rsp_out_valid, rsp_out_byte, rsp_out_end,
//                                             rsp_unclosed_error
// csr      in         csr_valid / csr_ready   csr_index, csr_data
//
// At most one req beat is accepted per cycle, none while req_stall is high. Each byte is
// judged against the one held from the previous beat in the same cycle; results are
// registered into a 4-entry result queue, so an rsp beat can show in the cycle after the
// acceptance that raised it. A last beat may raise two; req_stall rises while the queue
// lacks room for two. Synchronous reset clears scan state and queue, resets registers.

module comment_stripper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_end,
   output logic        rsp_unclosed_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import cstrip_pkg::*;

   // configuration registers
   cfg_type     cfg_ff;

   // scan state and the lookahead byte
   scan_type    scan_ff, scan_in;
   logic [7:0]  held_ff;
   logic        held_valid_ff, held_valid_in;
   logic        drop_ff, drop_in;

   logic        accept;
   logic        judge_held;
   scan_type    st1_raw, st1, st2_raw, st_end;
   logic        kept1_raw, sw1_raw, kept1, sw1;
   logic        kept2_raw, sw2_unused_ok, kept2;
   logic        end_err;

   result_type  r_held, r_end, push_a, push_b, head;
   logic [1:0]  push_cnt;
   logic        q_not_empty, q_almost_full;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign req_stall = q_almost_full;

   // Judge the held byte, with the new byte as its successor.
   assign judge_held = held_valid_ff && !drop_ff;

   cstrip_judge u_judge_held (
      .cfg      (cfg_ff),
      .st_in    (scan_ff),
      .cur      (held_ff),
      .nxt      (req_in_byte),
      .has_next (1'b1),
      .st_out   (st1_raw),
      .kept     (kept1_raw),
      .swallow  (sw1_raw)
   );

   assign st1   = judge_held ? st1_raw : scan_ff;
   assign kept1 = judge_held && kept1_raw;
   assign sw1   = judge_held && sw1_raw;

   // Judge the last byte with no successor, unless the held byte swallowed it.
   cstrip_judge u_judge_last (
      .cfg      (cfg_ff),
      .st_in    (st1),
      .cur      (req_in_byte),
      .nxt      (8'd0),
      .has_next (1'b0),
      .st_out   (st2_raw),
      .kept     (kept2_raw),
      .swallow  (sw2_unused_ok)
   );

   assign st_end  = sw1 ? st1 : st2_raw;
   assign kept2   = !sw1 && kept2_raw && !sw2_unused_ok;
   assign end_err = (st_end.mode == MODE_BLOCK) && (st_end.variant[15:8] != 8'd0);

   always_comb begin
      r_held.valid = 1'b1;
      r_held.data  = held_ff;
      r_held.last  = 1'b0;
      r_held.err   = 1'b0;
      r_end.valid  = kept2;
      r_end.data   = kept2 ? req_in_byte : 8'd0;
      r_end.last   = 1'b1;
      r_end.err    = end_err;
   end

   // Pack the beats of this input into the queue, held byte first.
   always_comb begin
      push_a   = r_end;
      push_b   = r_end;
      push_cnt = 2'd0;
      if (accept) begin
         if (req_in_last) begin
            if (kept1) begin
               push_a   = r_held;
               push_cnt = 2'd2;
            end else begin
               push_cnt = 2'd1;
            end
         end else if (kept1) begin
            push_a   = r_held;
            push_cnt = 2'd1;
         end
      end
   end

   // Advance the scan state; drop everything back to reset after the stream ends.
   always_comb begin
      scan_in       = scan_ff;
      held_valid_in = held_valid_ff;
      drop_in       = drop_ff;
      if (accept) begin
         if (req_in_last) begin
            scan_in.mode    = MODE_TEXT;
            scan_in.variant = 24'd0;
            held_valid_in   = 1'b0;
            drop_in         = 1'b0;
         end else begin
            scan_in       = st1;
            held_valid_in = 1'b1;
            drop_in       = sw1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.mode    <= MODE_TEXT;
         scan_ff.variant <= 24'd0;
         held_valid_ff   <= 1'b0;
         drop_ff         <= 1'b0;
      end else begin
         scan_ff       <= scan_in;
         held_valid_ff <= held_valid_in;
         drop_ff       <= drop_in;
      end
   end

   // hold the lookahead byte
   always_ff @(posedge clock) begin
      if (accept && !req_in_last) held_ff <= req_in_byte;
   end

   // Configuration writes; indexes beyond the list fall through untouched.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_op   <= '0;
         cfg_ff.line_op    <= '0;
         cfg_ff.dflt_block <= DFLT_BLOCK_RESET;
         cfg_ff.dflt_line  <= DFLT_LINE_RESET;
      end else if (csr_valid && csr_ready) begin
         for (int i = 0; i < NUM_VARIANTS; i++) begin
            if (csr_index == REG_BLOCK_A + 3'(i)) cfg_ff.block_op[i] <= csr_data;
            if (csr_index == REG_LINE_A + 3'(i))  cfg_ff.line_op[i]  <= csr_data[15:0];
         end
         if (csr_index == REG_DFLT_BLOCK) cfg_ff.dflt_block <= csr_data;
         if (csr_index == REG_DFLT_LINE)  cfg_ff.dflt_line  <= csr_data[15:0];
      end
   end

   cstrip_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_cnt    (push_cnt),
      .push_a      (push_a),
      .push_b      (push_b),
      .pop         (q_not_empty && !rsp_stall),
      .head        (head),
      .not_empty   (q_not_empty),
      .almost_full (q_almost_full)
   );

   assign rsp_valid          = q_not_empty;
   assign rsp_out_valid      = head.valid;
   assign rsp_out_byte       = head.data;
   assign rsp_out_end        = head.last;
   assign rsp_unclosed_error = head.err;

endmodule

### rtl/cstrip_judge.sv
`timescale 1ns / 1ps

module cstrip_judge (
   input  cstrip_pkg::cfg_type  cfg,
   input  cstrip_pkg::scan_type st_in,
   input  logic [7:0]           cur,
   input  logic [7:0]           nxt,
   input  logic                 has_next,
   output cstrip_pkg::scan_type st_out,
   output logic                 kept,
   output logic                 swallow
);
   import cstrip_pkg::*;

   typedef struct packed {
      logic     hit;
      scan_type st;
      logic     swallow;
   } hit_type;

   function automatic logic opener_hit(logic [15:0] op, logic [7:0] c, logic [7:0] n,
                                       logic hn);
      return (op[7:0] != 8'd0) && (c == op[7:0]) &&
             ((op[15:8] == 8'd0) || (hn && (n == op[15:8])));
   endfunction

   // Try openers in priority order: block table, line table, default block, default line.
   function automatic hit_type search_open(cfg_type c, logic [7:0] b, logic [7:0] n,
                                           logic hn);
      hit_type r;
      r.hit        = 1'b0;
      r.st.mode    = MODE_TEXT;
      r.st.variant = 24'd0;
      r.swallow    = 1'b0;
      for (int i = 0; i < NUM_VARIANTS; i++) begin
         if (!r.hit && opener_hit(c.block_op[i][15:0], b, n, hn)) begin
            r.hit        = 1'b1;
            r.st.mode    = MODE_BLOCK;
            r.st.variant = c.block_op[i];
            r.swallow    = c.block_op[i][15:8] != 8'd0;
         end
      end
      for (int i = 0; i < NUM_VARIANTS; i++) begin
         if (!r.hit && opener_hit(c.line_op[i], b, n, hn)) begin
            r.hit        = 1'b1;
            r.st.mode    = MODE_LINE;
            r.st.variant = {8'd0, c.line_op[i]};
            r.swallow    = c.line_op[i][15:8] != 8'd0;
         end
      end
      if (!r.hit && opener_hit(c.dflt_block[15:0], b, n, hn)) begin
         r.hit        = 1'b1;
         r.st.mode    = MODE_BLOCK;
         r.st.variant = c.dflt_block;
         r.swallow    = c.dflt_block[15:8] != 8'd0;
      end
      if (!r.hit && opener_hit(c.dflt_line, b, n, hn)) begin
         r.hit        = 1'b1;
         r.st.mode    = MODE_LINE;
         r.st.variant = {8'd0, c.dflt_line};
         r.swallow    = c.dflt_line[15:8] != 8'd0;
      end
      return r;
   endfunction

   hit_type     srch;
   logic [7:0]  close_o2;
   logic [7:0]  close_fin;

   assign srch      = search_open(cfg, cur, nxt, has_next);
   assign close_o2  = st_in.variant[15:8];
   assign close_fin = (st_in.variant[23:16] == 8'd0) ? st_in.variant[7:0]
                                                     : st_in.variant[23:16];

   always_comb begin
      st_out  = st_in;
      kept    = 1'b0;
      swallow = 1'b0;
      case (st_in.mode)
         MODE_BLOCK: begin
            if (close_o2 == 8'd0) begin
               if (cur == close_fin) st_out.mode = MODE_TEXT;
            end else if (has_next && (cur == close_o2) && (nxt == close_fin)) begin
               st_out.mode = MODE_TEXT;
               swallow     = 1'b1;
            end
         end
         MODE_LINE: begin
            if (cur == NEWLINE_BYTE) begin
               // newline closes the comment and is judged again as text
               st_out.mode = srch.st.mode;
               if (srch.hit) st_out.variant = srch.st.variant;
               kept    = !srch.hit;
               swallow = srch.swallow;
            end else if (!has_next) begin
               st_out.mode = MODE_TEXT;
            end
         end
         default: begin
            st_out.mode = srch.st.mode;
            if (srch.hit) st_out.variant = srch.st.variant;
            kept    = !srch.hit;
            swallow = srch.swallow;
         end
      endcase
   end

endmodule

### rtl/cstrip_fifo.sv
`timescale 1ns / 1ps

module cstrip_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_cnt,
   input  cstrip_pkg::result_type push_a,
   input  cstrip_pkg::result_type push_b,
   input  logic                   pop,
   output cstrip_pkg::result_type head,
   output logic                   not_empty,
   output logic                   almost_full
);
   import cstrip_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   result_type       mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign wr_in    = wr_ff + PTR_W'(push_cnt);
   assign rd_in    = rd_ff + PTR_W'(pop);
   assign count_in = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);

   assign head        = mem_ff[rd_ff];
   assign not_empty   = count_ff != CNT_W'(0);
   // leave room for the two beats one input can raise
   assign almost_full = count_ff > CNT_W'(FIFO_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) mem_ff[wr_ff] <= push_a;
      if (push_cnt == 2'd2) mem_ff[wr_ff + PTR_W'(1)] <= push_b;
   end

endmodule

### test/comment_stripper_check.sv
`timescale 1ns / 1ps

module comment_stripper_check
   import cstrip_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_out_valid,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_out_end,
   input  logic        rsp_unclosed_error,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data,
   output int          outstanding,
   output int          fail_count
);

   logic [23:0] block_tab [2];
   logic [15:0] line_tab [2];
   logic [23:0] dflt_block;
   logic [15:0] dflt_line;

   scan_type    scan;
   logic [7:0]  held_byte;
   bit          held_valid;
   bit          drop_held;

   result_type  stripped_q [$];
   int          failures = 0;

   assign fail_count = failures;

   function automatic bit opener_fits(input logic [23:0] v, input logic [7:0] cur,
                                      input logic [7:0] nxt, input bit has_next);
      if (v[7:0] == 8'h00 || cur != v[7:0]) return 1'b0;
      if (v[15:8] == 8'h00) return 1'b1;
      return has_next && nxt == v[15:8];
   endfunction

   // Try the openers in priority order; return 1 when cur stays text.
   function automatic bit open_search(input logic [7:0] cur, input logic [7:0] nxt,
                                      input bit has_next, output bit swallow);
      logic [23:0] found;
      mode_type    found_mode;
      bit          hit;
      hit = 1'b0;
      found = '0;
      found_mode = MODE_TEXT;
      for (int i = 0; i < NUM_VARIANTS; i++) begin
         if (!hit && opener_fits(block_tab[i], cur, nxt, has_next)) begin
            hit = 1'b1;
            found = block_tab[i];
            found_mode = MODE_BLOCK;
         end
      end
      for (int i = 0; i < NUM_VARIANTS; i++) begin
         if (!hit && opener_fits({8'h00, line_tab[i]}, cur, nxt, has_next)) begin
            hit = 1'b1;
            found = {8'h00, line_tab[i]};
            found_mode = MODE_LINE;
         end
      end
      if (!hit && opener_fits(dflt_block, cur, nxt, has_next)) begin
         hit = 1'b1;
         found = dflt_block;
         found_mode = MODE_BLOCK;
      end
      if (!hit && opener_fits({8'h00, dflt_line}, cur, nxt, has_next)) begin
         hit = 1'b1;
         found = {8'h00, dflt_line};
         found_mode = MODE_LINE;
      end
      swallow = hit && found[15:8] != 8'h00;
      scan.mode = found_mode;
      if (hit) scan.variant = found;
      return !hit;
   endfunction

   // Judge one byte against the scan state; return 1 when it is kept.
   function automatic bit classify_byte(input logic [7:0] cur, input logic [7:0] nxt,
                                        input bit has_next, output bit swallow);
      logic [7:0] close_char;
      swallow = 1'b0;
      close_char = (scan.variant[23:16] != 8'h00) ? scan.variant[23:16] : scan.variant[7:0];
      case (scan.mode)
         MODE_BLOCK: begin
            if (scan.variant[15:8] == 8'h00) begin
               if (cur == close_char) scan.mode = MODE_TEXT;
            end else if (has_next && cur == scan.variant[15:8] && nxt == close_char) begin
               scan.mode = MODE_TEXT;
               swallow = 1'b1;
            end
            return 1'b0;
         end
         MODE_LINE: begin
            // a newline ends the comment and is judged again as text
            if (cur == NEWLINE_BYTE) return open_search(cur, nxt, has_next, swallow);
            if (!has_next) scan.mode = MODE_TEXT;
            return 1'b0;
         end
         default: return open_search(cur, nxt, has_next, swallow);
      endcase
   endfunction

   function automatic void clear_scan();
      scan.mode = MODE_TEXT;
      scan.variant = '0;
      held_byte = '0;
      held_valid = 1'b0;
      drop_held = 1'b0;
   endfunction

   // Advance the stream by one accepted beat and queue the bytes it releases.
   function automatic void strip_step(input logic [7:0] b, input bit last);
      bit         taken;
      bit         sw;
      bit         kept;
      result_type r;
      taken = 1'b0;
      sw = 1'b0;
      kept = 1'b0;
      if (held_valid && !drop_held) begin
         if (classify_byte(held_byte, b, 1'b1, sw)) begin
            r.valid = 1'b1;
            r.data = held_byte;
            r.last = 1'b0;
            r.err = 1'b0;
            stripped_q = {stripped_q, r};
         end
         taken = sw;
      end
      if (last) begin
         if (!taken) kept = classify_byte(b, 8'h00, 1'b0, sw);
         r.valid = kept;
         r.data = kept ? b : 8'h00;
         r.last = 1'b1;
         r.err = scan.mode == MODE_BLOCK && scan.variant[15:8] != 8'h00;
         stripped_q = {stripped_q, r};
         clear_scan();
      end else begin
         held_byte = b;
         held_valid = 1'b1;
         drop_held = taken;
      end
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         block_tab[0] = '0;
         block_tab[1] = '0;
         line_tab[0] = '0;
         line_tab[1] = '0;
         dflt_block = DFLT_BLOCK_RESET;
         dflt_line = DFLT_LINE_RESET;
         clear_scan();
         stripped_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BLOCK_A, REG_BLOCK_A + 3'd1:
                  block_tab[1'(csr_index - REG_BLOCK_A)] = csr_data;
               REG_LINE_A, REG_LINE_A + 3'd1:
                  line_tab[1'(csr_index - REG_LINE_A)] = csr_data[15:0];
               REG_DFLT_BLOCK: dflt_block = csr_data;
               REG_DFLT_LINE:  dflt_line = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) strip_step(req_in_byte, req_in_last);
         if (rsp_valid && !rsp_stall) begin
            if (stripped_q.size() == 0) begin
               $display("%0t: beat expected none got valid=%0b byte=%0h end=%0b err=%0b",
                        $time, rsp_out_valid, rsp_out_byte, rsp_out_end, rsp_unclosed_error);
               failures++;
            end else begin
               want = stripped_q.pop_front();
               check_field("out_valid", want.valid, rsp_out_valid);
               check_field("out_byte", want.data, rsp_out_byte);
               check_field("out_end", want.last, rsp_out_end);
               check_field("unclosed_error", want.err, rsp_unclosed_error);
            end
         end
      end
      outstanding <= stripped_q.size();
   end

endmodule

### test/comment_stripper_test.sv
`timescale 1ns / 1ps

module comment_stripper_test;
   import cstrip_pkg::*;

   // The package names only some of the register indexes; derive the rest.
   localparam logic [2:0] REG_BLOCK_B  = REG_BLOCK_A + 3'd1;
   localparam logic [2:0] REG_LINE_B   = REG_LINE_A + 3'd1;
   localparam logic [2:0] REG_SPARE_LO = REG_DFLT_LINE + 3'd1;
   localparam logic [2:0] REG_SPARE_HI = REG_DFLT_LINE + 3'd2;

   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_BYTES   = 200;
   localparam int DRAIN_CYCLES  = 6;     // margin after the queue drains
   localparam int LONG_HOLD     = 120;   // result side frozen long enough to back up req
   localparam int LIMIT_CYCLES  = 500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_in_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_out_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_end;
   logic        rsp_unclosed_error;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [23:0] csr_data = 24'h0;

   int          outstanding;
   int          fail_count;

   // Sender pacing: bursts of random length, and a chance of a gap before each burst.
   int          burst_left = 0;
   int          gap_pct = 30;
   // Set once to ask the receiver for its long hold-off.
   bit          squeeze_req = 1'b0;

   // Register values last programmed, and the bytes they use as delimiters. Random text
   // leans on these bytes so that openers and closers actually show up.
   logic [23:0] reg_copy [6];
   logic [7:0]  hot_chars [$];

   comment_stripper i_dut (.*);

   comment_stripper_check i_check (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block wedges or a beat never comes back.
   initial begin
      #(LIMIT_CYCLES * 12);
      $display("FAIL comment_stripper");
      $finish;
   end

   // Result side: stall on a pattern of its own. Each spell picks a style - flow freely,
   // stall now and then, alternate every cycle, or stall most of the time. Once asked,
   // hold off for a long stretch so the result queue fills and req_stall rises.
   initial begin
      int spell;
      int style;
      bit squeezed;
      squeezed = 1'b0;
      forever begin
         style = $urandom_range(3);
         spell = $urandom_range(8, 60);
         for (int c = 0; c < spell; c++) begin
            @(posedge clock);
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= $urandom_range(99) < 30;
               2: rsp_stall <= c[0];
               default: rsp_stall <= $urandom_range(99) < 75;
            endcase
         end
         if (squeeze_req && !squeezed) begin
            squeezed = 1'b1;
            @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one beat and hold it until the block takes it. Valid stays high into the
   // next beat unless a gap is drawn at the start of a burst.
   task automatic send_byte(input logic [7:0] b, input bit last);
      if (burst_left == 0) begin
         if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Send a string; mark its final byte as the end of the stream when asked.
   task automatic send_text(input string s, input bit ends);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], ends && i == s.len() - 1);
   endtask

   // Drop valid and wait until every predicted beat has come back, then wait out DRAIN_CYCLES.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write of a batch.
   task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Program every register from reg_copy, poke one of the spare indexes past the end, and collect
   // the delimiter bytes for the text generator.
   task automatic load_regs();
      for (int r = REG_BLOCK_A; r <= REG_DFLT_LINE; r++) write_reg(3'(r), reg_copy[r]);
      write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, 24'($urandom));
      csr_valid <= 1'b0;
      hot_chars.delete();
      hot_chars = {hot_chars, NEWLINE_BYTE};
      for (int r = REG_BLOCK_A; r <= REG_DFLT_LINE; r++) begin
         for (int k = 0; k < 3; k++) begin
            if (reg_copy[r][8*k +: 8] != 8'h00) hot_chars = {hot_chars, reg_copy[r][8*k +: 8]};
         end
      end
      @(posedge clock);
   endtask

   // Draw one register value. Mostly punctuation from a small pool so that variants
   // share characters and table priority matters; sometimes disabled, all ones or noise.
   // Line registers take the upper byte too, which the block must ignore.
   function automatic logic [23:0] pick_delim();
      string      pool;
      logic [7:0] o1;
      logic [7:0] o2;
      logic [7:0] cl;
      pool = "/*#;{}()-!\n";
      o1 = pool[$urandom_range(pool.len() - 1)];
      o2 = $urandom_range(1) ? pool[$urandom_range(pool.len() - 1)] : 8'h00;
      cl = ($urandom_range(3) == 0) ? 8'h00 : pool[$urandom_range(pool.len() - 1)];
      case ($urandom_range(9))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         2: return 24'($urandom);
         default: return {cl, o2, o1};
      endcase
   endfunction

   initial begin
      int sent;
      int len;
      logic [7:0] b;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at reset: slash-star block and double-slash line comments only.
      send_text("a/*x*/b", 1'b1);      // block comment between two kept bytes
      send_text("//c\nd", 1'b1);       // newline closes the line comment and is kept
      send_byte(8'h00, 1'b0);          // zero byte is plain text, not an end marker
      send_byte(8'hFF, 1'b1);
      send_text("/*", 1'b1);           // two-char opener on the last two bytes: error
      send_text("//z", 1'b1);          // line comment closed by end of stream
      settle();

      reg_copy[REG_BLOCK_A]    = 24'h292A28;                  // "(*" closed by "*)"
      reg_copy[REG_BLOCK_B]    = 24'h7D007B;                  // "{" closed by "}"
      reg_copy[REG_LINE_A]     = 24'h000023;                  // "#"
      reg_copy[REG_LINE_B]     = 24'h002D2D;                  // "--"
      reg_copy[REG_DFLT_BLOCK] = DFLT_BLOCK_RESET;
      reg_copy[REG_DFLT_LINE]  = {8'h00, DFLT_LINE_RESET};
      load_regs();

      // Open a brace comment, then drop that variant mid-comment: the open comment
      // must still close on the brace it latched.
      send_text("{ab", 1'b0);
      settle();
      reg_copy[REG_BLOCK_B] = 24'h000000;
      load_regs();
      send_text("}c", 1'b1);

      // Random phases: all disabled, all ones, then drawn settings. Streams end at the
      // phase boundary so registers only change while the block is quiet.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         for (int r = REG_BLOCK_A; r <= REG_DFLT_LINE; r++) begin
            if (p == 0) reg_copy[r] = 24'h000000;
            else if (p == 1) reg_copy[r] = 24'hFFFFFF;
            else reg_copy[r] = pick_delim();
         end
         load_regs();
         gap_pct = (p % 3 == 2) ? 0 : 35;
         if (p == 2) squeeze_req <= 1'b1;
         sent = 0;
         while (sent < PHASE_BYTES) begin
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 30);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(99) < 60) b = hot_chars[$urandom_range(hot_chars.size() - 1)];
               else b = 8'($urandom);
               send_byte(b, i == len - 1);
            end
            sent += len;
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("PASS comment_stripper");
      end else begin
         $display("FAIL comment_stripper");
      end
      $finish;
   end

endmodule
